### rtl/ccpe_pkg.sv
// Shared constants, word layouts and small helpers for the cubic curve point evaluator.
// No dependencies; imported by cubic_curve_point_evaluator_top.

package ccpe_pkg;

	// Fixed point format of parameters and weights
	localparam int FRAC_BITS = 16;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int HALF      = 1 << (FRAC_BITS - 1);

	// Field and datapath widths
	localparam int PRM_W   = FRAC_BITS + 1;    // Q1.FRAC parameter, 0..ONE
	localparam int SQ_W    = 2 * PRM_W;        // product of two parameters
	localparam int PT_W    = 32;               // control / result value
	localparam int CTL_W   = PT_W + 2;         // control after phantom extrapolation
	localparam int NUM_W   = FRAC_BITS + 5;    // signed weight numerator
	localparam int MAG_W   = NUM_W - 1;        // numerator magnitude
	localparam int W_W     = FRAC_BITS + 4;    // signed final weight
	localparam int PROD_W  = W_W + CTL_W;      // weight times control
	localparam int ACC_W   = PROD_W + 2;       // sum of four products
	localparam int RCP_W   = 2 * NUM_W;        // reciprocal product
	localparam int NUM_STG = 12;               // pipeline depth

	// Divide by six: floor(x / 6) = (x * RECIP6) >> RECIP_SH for x below 2**NUM_W
	localparam int RECIP_SH = NUM_W + 2;
	localparam logic [NUM_W-1:0] RECIP6 = NUM_W'(((64'd1 << RECIP_SH) + 64'd5) / 64'd6);

	// Curve mode codes
	localparam logic [1:0] MODE_LINEAR  = 2'd0;
	localparam logic [1:0] MODE_BEZIER  = 2'd1;
	localparam logic [1:0] MODE_BSPLINE = 2'd2;
	localparam logic [1:0] MODE_CATROM  = 2'd3;

	// Weight divisor codes
	localparam logic [1:0] DIV_NONE = 2'd0;
	localparam logic [1:0] DIV_TWO  = 2'd1;
	localparam logic [1:0] DIV_SIX  = 2'd2;

	// Input word layout (tdata), lowest field first
	localparam int LP_LSB     = 0;
	localparam int SS_LSB     = LP_LSB + PRM_W;
	localparam int SE_LSB     = SS_LSB + PRM_W;
	localparam int PT_LSB     = SE_LSB + PRM_W;
	localparam int NB_LSB     = PT_LSB + 4 * PT_W;
	localparam int IN_BITS    = NB_LSB + 4 * PT_W;
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int IN_USER_W  = 4;

	// Output word layout (tdata): curve_value, mapped_param
	localparam int OUT_BITS   = PT_W + PRM_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Numerator constants
	localparam logic signed [NUM_W-1:0] N_ONE  = NUM_W'(ONE);
	localparam logic signed [NUM_W-1:0] N_TWO  = NUM_W'(2 * ONE);
	localparam logic signed [NUM_W-1:0] N_FOUR = NUM_W'(4 * ONE);

	// Saturation bounds of the result
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sh7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(signed'(32'h8000_0000));

	typedef logic signed [CTL_W-1:0] ctl_t;
	typedef logic signed [NUM_W-1:0] num_t;
	typedef logic signed [W_W-1:0]   wgt_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// Sideband that rides along the pipeline
	typedef struct packed {
		logic             fail;
		logic [PRM_W-1:0] m;
	} meta_t;

	// Round to nearest, half up, and drop the fraction
	function automatic logic [PRM_W-1:0] rnd_q(input logic [SQ_W-1:0] x);
		logic [SQ_W-1:0] s;
		s = x + SQ_W'(HALF);
		return PRM_W'(s >> FRAC_BITS);
	endfunction

	// Small constant multiples by shift and add
	function automatic num_t x2(input num_t x);
		return x <<< 1;
	endfunction

	function automatic num_t x3(input num_t x);
		return (x <<< 1) + x;
	endfunction

	function automatic num_t x4(input num_t x);
		return x <<< 2;
	endfunction

	function automatic num_t x5(input num_t x);
		return (x <<< 2) + x;
	endfunction

	function automatic num_t x6(input num_t x);
		return (x <<< 2) + (x <<< 1);
	endfunction

endpackage

### rtl/cubic_curve_point_evaluator_top.sv
// Cubic curve point evaluator: twelve stage pipeline with an input skid register.
// Depends on ccpe_pkg for widths, layouts, mode codes and rounding helpers.

// One word per clock in and out when the output is not stalled. All stages advance
// together on one enable, which holds while the output register is full and not taken.
// A word that arrives on a held cycle lands in a single skid register, and tready then
// stays low until the first enabled cycle, in which that word moves into the first stage.
// The curve_mode register is sampled at the weight stage, so it must only change when the
// pipeline is empty. Stage plan: range check and phantom controls, segment product, mapped
// parameter, squares, cubes and cross terms, weight numerators, divide by six via
// reciprocal multiply or by two via halving, signed weights, four weight-control products,
// pair sums, total, then rounding and saturation into the output register.

module cubic_curve_point_evaluator_top
	import ccpe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_wr_en,
	input  logic [1:0]            cfg_wr_data,   // curve_mode
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// local_param, seg_start, seg_end, point_a..point_d, nbr_a..nbr_d, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [IN_USER_W-1:0]  s_axis_tuser,  // phantom_mask
	// output stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // curve_value, mapped_param, zero pad
	output logic [0:0]            m_axis_tuser   // sample_ok
);

	// ---------------------------------------------------------------
	// Config register
	logic [1:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LINEAR;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// ---------------------------------------------------------------
	// Pipeline enable and input skid
	logic                 en;
	logic                 in_acc;
	logic                 in_vld;
	logic                 skid_vld_q;
	logic [IN_DATA_W-1:0] skid_data_q;
	logic [IN_USER_W-1:0] skid_user_q;
	logic [IN_DATA_W-1:0] in_data;
	logic [IN_USER_W-1:0] in_user;
	logic [NUM_STG-1:0]   vld_q;

	assign en            = !vld_q[NUM_STG-1] || m_axis_tready;
	assign s_axis_tready = !skid_vld_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_vld        = skid_vld_q || in_acc;
	assign in_data       = skid_vld_q ? skid_data_q : s_axis_tdata;
	assign in_user       = skid_vld_q ? skid_user_q : s_axis_tuser;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en) begin
			skid_vld_q <= 1'b0;
		end else if (in_acc) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && in_acc) begin
			skid_data_q <= s_axis_tdata;
			skid_user_q <= s_axis_tuser;
		end
	end

	// Valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NUM_STG-2:0], in_vld};
		end
	end

	// ---------------------------------------------------------------
	// Stage 1 inputs: field unpack, range check, phantom controls
	logic [PRM_W-1:0]       lp_in, ss_in, se_in;
	logic                   fail_in;
	logic signed [PT_W-1:0] pt_in [4];
	logic signed [PT_W-1:0] nb_in [4];
	ctl_t                   ctl_in [4];

	assign lp_in   = in_data[LP_LSB +: PRM_W];
	assign ss_in   = in_data[SS_LSB +: PRM_W];
	assign se_in   = in_data[SE_LSB +: PRM_W];
	assign fail_in = (lp_in > PRM_W'(ONE)) || (ss_in > se_in) || (se_in > PRM_W'(ONE));

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pt_in[i] = in_data[PT_LSB + i * PT_W +: PT_W];
			nb_in[i] = in_data[NB_LSB + i * PT_W +: PT_W];
			if (in_user[i]) begin
				ctl_in[i] = (CTL_W'(pt_in[i]) <<< 1) - CTL_W'(nb_in[i]);
			end else begin
				ctl_in[i] = CTL_W'(pt_in[i]);
			end
		end
	end

	// ---------------------------------------------------------------
	// Stages 1 to 5: parameter mapping and powers
	logic [PRM_W-1:0] u_s1, u0_s1, diff_s1;
	logic             fail_s1, fail_s2;
	ctl_t             ctl_s1 [4];
	logic [SQ_W-1:0]  prod_s2;
	logic [PRM_W-1:0] u0_s2;
	ctl_t             ctl_s2 [4];
	logic [PRM_W-1:0] m_c;
	meta_t            meta_s3;
	logic [PRM_W-1:0] om_s3;
	ctl_t             ctl_s3 [4];
	logic [SQ_W-1:0]  mm_c, oo_c;
	meta_t            meta_s4;
	logic [PRM_W-1:0] om_s4, m2_s4, om2_s4;
	ctl_t             ctl_s4 [4];
	logic [SQ_W-1:0]  m3p_c, om3p_c, mom2p_c, m2omp_c;
	meta_t            meta_s5;
	logic [PRM_W-1:0] om_s5, m2_s5, m3_s5, om3_s5, mom2_s5, m2om_s5;
	ctl_t             ctl_s5 [4];

	assign m_c     = u0_s2 + rnd_q(prod_s2);
	assign mm_c    = meta_s3.m * meta_s3.m;
	assign oo_c    = om_s3 * om_s3;
	assign m3p_c   = m2_s4 * meta_s4.m;
	assign om3p_c  = om2_s4 * om_s4;
	assign mom2p_c = meta_s4.m * om2_s4;
	assign m2omp_c = m2_s4 * om_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			u_s1    <= lp_in;
			u0_s1   <= ss_in;
			diff_s1 <= se_in - ss_in;
			fail_s1 <= fail_in;
			ctl_s1  <= ctl_in;
			// stage 2: u * (u1 - u0)
			prod_s2 <= u_s1 * diff_s1;
			u0_s2   <= u0_s1;
			fail_s2 <= fail_s1;
			ctl_s2  <= ctl_s1;
			// stage 3: m and 1 - m
			meta_s3 <= '{fail: fail_s2, m: m_c};
			om_s3   <= PRM_W'(ONE) - m_c;
			ctl_s3  <= ctl_s2;
			// stage 4: squares
			meta_s4 <= meta_s3;
			om_s4   <= om_s3;
			m2_s4   <= rnd_q(mm_c);
			om2_s4  <= rnd_q(oo_c);
			ctl_s4  <= ctl_s3;
			// stage 5: cubes and cross terms
			meta_s5 <= meta_s4;
			om_s5   <= om_s4;
			m2_s5   <= m2_s4;
			m3_s5   <= rnd_q(m3p_c);
			om3_s5  <= rnd_q(om3p_c);
			mom2_s5 <= rnd_q(mom2p_c);
			m2om_s5 <= rnd_q(m2omp_c);
			ctl_s5  <= ctl_s4;
		end
	end

	// ---------------------------------------------------------------
	// Stage 6: weight numerators per curve mode
	num_t       nm, nom, nm2, nm3, nom3, nmom2, nm2om;
	num_t       num_c [4];
	logic [1:0] kind_c;

	assign nm    = NUM_W'(meta_s5.m);
	assign nom   = NUM_W'(om_s5);
	assign nm2   = NUM_W'(m2_s5);
	assign nm3   = NUM_W'(m3_s5);
	assign nom3  = NUM_W'(om3_s5);
	assign nmom2 = NUM_W'(mom2_s5);
	assign nm2om = NUM_W'(m2om_s5);

	always_comb begin
		unique case (mode_q)
			MODE_LINEAR: begin
				num_c[0] = nom;
				num_c[1] = nm;
				num_c[2] = '0;
				num_c[3] = '0;
				kind_c   = DIV_NONE;
			end
			MODE_BEZIER: begin
				num_c[0] = nom3;
				num_c[1] = x3(nmom2);
				num_c[2] = x3(nm2om);
				num_c[3] = nm3;
				kind_c   = DIV_NONE;
			end
			MODE_BSPLINE: begin
				num_c[0] = nom3;
				num_c[1] = x3(nm3) - x6(nm2) + N_FOUR;
				num_c[2] = x3(nm2) + x3(nm) + N_ONE - x3(nm3);
				num_c[3] = nm3;
				kind_c   = DIV_SIX;
			end
			MODE_CATROM: begin
				num_c[0] = x2(nm2) - nm3 - nm;
				num_c[1] = x3(nm3) - x5(nm2) + N_TWO;
				num_c[2] = x4(nm2) + nm - x3(nm3);
				num_c[3] = nm3 - nm2;
				kind_c   = DIV_TWO;
			end
			default: begin
				num_c[0] = '0;
				num_c[1] = '0;
				num_c[2] = '0;
				num_c[3] = '0;
				kind_c   = DIV_NONE;
			end
		endcase
	end

	meta_t      meta_s6;
	num_t       num_s6 [4];
	logic [1:0] kind_s6;
	ctl_t       ctl_s6 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s6 <= meta_s5;
			num_s6  <= num_c;
			kind_s6 <= kind_c;
			ctl_s6  <= ctl_s5;
		end
	end

	// ---------------------------------------------------------------
	// Stage 7: magnitude, reciprocal multiply for /6, halving for /2
	// Both divides round half away from zero: add half the divisor to the magnitude.
	logic [MAG_W-1:0] mag_c [4];
	logic [NUM_W-1:0] rx_c  [4];
	logic [MAG_W-1:0] alt_c [4];
	logic [NUM_W-1:0] hx_c  [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag_c[i] = num_s6[i][NUM_W-1] ? MAG_W'(-num_s6[i]) : MAG_W'(num_s6[i]);
			rx_c[i]  = NUM_W'(mag_c[i]) + NUM_W'(3);
			hx_c[i]  = NUM_W'(mag_c[i]) + NUM_W'(1);
			alt_c[i] = (kind_s6 == DIV_TWO) ? MAG_W'(hx_c[i] >> 1) : mag_c[i];
		end
	end

	meta_t            meta_s7;
	logic [RCP_W-1:0] pr_s7  [4];
	logic [MAG_W-1:0] alt_s7 [4];
	logic [3:0]       neg_s7;
	logic [1:0]       kind_s7;
	ctl_t             ctl_s7 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s7 <= meta_s6;
			kind_s7 <= kind_s6;
			ctl_s7  <= ctl_s6;
			for (int i = 0; i < 4; i++) begin
				pr_s7[i]  <= rx_c[i] * RECIP6;
				alt_s7[i] <= alt_c[i];
				neg_s7[i] <= num_s6[i][NUM_W-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 8: signed weights
	logic [W_W-1:0] q_c [4];
	wgt_t           w_c [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			q_c[i] = (kind_s7 == DIV_SIX) ? W_W'(pr_s7[i] >> RECIP_SH) : W_W'(alt_s7[i]);
			w_c[i] = neg_s7[i] ? -q_c[i] : q_c[i];
		end
	end

	meta_t meta_s8;
	wgt_t  w_s8   [4];
	ctl_t  ctl_s8 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s8 <= meta_s7;
			w_s8    <= w_c;
			ctl_s8  <= ctl_s7;
		end
	end

	// ---------------------------------------------------------------
	// Stages 9 to 11: weighted products and their sum
	meta_t                    meta_s9, meta_s10, meta_s11;
	prod_t                    prd_s9 [4];
	logic signed [ACC_W-1:0]  sum_lo_s10, sum_hi_s10;
	logic signed [ACC_W-1:0]  acc_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s9    <= meta_s8;
			for (int i = 0; i < 4; i++) begin
				prd_s9[i] <= w_s8[i] * ctl_s8[i];
			end
			meta_s10   <= meta_s9;
			sum_lo_s10 <= ACC_W'(prd_s9[0]) + ACC_W'(prd_s9[1]);
			sum_hi_s10 <= ACC_W'(prd_s9[2]) + ACC_W'(prd_s9[3]);
			meta_s11   <= meta_s10;
			acc_s11    <= sum_lo_s10 + sum_hi_s10;
		end
	end

	// ---------------------------------------------------------------
	// Stage 12: divide by ONE half away from zero, saturate, output register
	logic signed [ACC_W-1:0] rnd_c;
	logic signed [ACC_W-1:0] sh_c;
	logic [PT_W-1:0]         val_c;
	logic [PT_W-1:0]         value_s12;
	logic [PRM_W-1:0]        mapped_s12;
	logic                    ok_s12;

	assign rnd_c = acc_s11 + (acc_s11[ACC_W-1] ? ACC_W'(HALF - 1) : ACC_W'(HALF));
	assign sh_c  = rnd_c >>> FRAC_BITS;

	always_comb begin
		if (sh_c > SAT_MAX) begin
			val_c = PT_W'(SAT_MAX);
		end else if (sh_c < SAT_MIN) begin
			val_c = PT_W'(SAT_MIN);
		end else begin
			val_c = sh_c[PT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_s12  <= meta_s11.fail ? '0 : val_c;
			mapped_s12 <= meta_s11.fail ? '0 : meta_s11.m;
			ok_s12     <= !meta_s11.fail;
		end
	end

	assign m_axis_tvalid = vld_q[NUM_STG-1];
	assign m_axis_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, mapped_s12, value_s12};
	assign m_axis_tuser  = ok_s12;

	// ---------------------------------------------------------------
	// Checks
`ifndef SYNTHESIS
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("failed word carries nonzero data");

	a_mapped_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> mapped_s12 <= PRM_W'(ONE))
		else $error("mapped parameter above one");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !en |=> skid_vld_q)
		else $error("word accepted on a held cycle was not kept");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !en |=> skid_vld_q && $stable(skid_data_q))
		else $error("skid word lost while pipeline held");
`endif

endmodule

### tb/sv/tb_cubic_curve_point_evaluator_top.sv
// Self-checking testbench for cubic_curve_point_evaluator_top: a directed table, then random
// samples under several idle patterns, each result checked against a fixed expected point or an in-bench curve model.
// Depends on ccpe_pkg and cubic_curve_point_evaluator_top.

`timescale 1ns / 100ps

module tb_cubic_curve_point_evaluator_top;
	import ccpe_pkg::*;

	localparam logic [PT_W-1:0] V_MAX = 32'h7FFF_FFFF;
	localparam logic [PT_W-1:0] V_MIN = 32'h8000_0000;
	localparam int PRM_MAX = (1 << PRM_W) - 1;
	localparam longint VAL_HI = 64'sd2147483647;
	localparam longint VAL_LO = -64'sd2147483648;
	localparam int WD_LIMIT = 1000;
	localparam int RAND_BLOCKS = 8;
	localparam int BLOCK_ITEMS = 80;

	// one input sample, controls and neighbours indexed a..d as 0..3
	typedef struct packed {
		logic [PRM_W-1:0]           local_param;
		logic [PRM_W-1:0]           seg_start;
		logic [PRM_W-1:0]           seg_end;
		logic [3:0][PT_W-1:0]       ctl;
		logic [3:0][PT_W-1:0]       nbr;
		logic [3:0]                 phantom;
	} sample_t;

	// one evaluated point
	typedef struct packed {
		logic [PT_W-1:0]  value;
		logic [PRM_W-1:0] mparam;
		logic             ok;
	} point_t;

	typedef struct {
		logic [1:0] md;
		sample_t    smp;
		bit         fixed;
		point_t     want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [1:0]            cfg_wr_data = MODE_LINEAR;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [0:0]            m_axis_tuser;

	point_t   pending_points[$];
	dir_row_t dir_rows[$];
	logic [1:0] cur_mode = MODE_LINEAR;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	point_t got_pt;
	point_t want_pt;

	cubic_curve_point_evaluator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// round to nearest, half up, drop the fraction (x is never negative)
	function automatic longint q_round(input longint x);
		return (x + longint'(HALF)) >>> FRAC_BITS;
	endfunction

	// divide, rounding half away from zero
	function automatic longint div_away(input longint n, input longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	// expected point for one sample under the given curve mode
	function automatic point_t eval_curve_point(input sample_t s, input logic [1:0] md);
		longint one, u, u0, u1, m, m2, m3, om, om2, om3, acc, r, p;
		longint cv[4];
		longint w[4];
		point_t res;
		int i;
		one = longint'(ONE);
		u = longint'(s.local_param);
		u0 = longint'(s.seg_start);
		u1 = longint'(s.seg_end);
		res = '0;
		if (u > one || u0 > u1 || u1 > one)
			return res;
		m = u0 + q_round(u * (u1 - u0));
		// phantom controls are extrapolated at full width
		for (i = 0; i < 4; i++) begin
			p = longint'($signed(s.ctl[i]));
			if (s.phantom[i])
				p = 2 * p - longint'($signed(s.nbr[i]));
			cv[i] = p;
		end
		m2 = q_round(m * m);
		m3 = q_round(m2 * m);
		om = one - m;
		om2 = q_round(om * om);
		om3 = q_round(om2 * om);
		case (md)
			MODE_LINEAR: begin
				w[0] = one - m;
				w[1] = m;
				w[2] = 0;
				w[3] = 0;
			end
			MODE_BEZIER: begin
				w[0] = om3;
				w[1] = 3 * q_round(m * om2);
				w[2] = 3 * q_round(m2 * om);
				w[3] = m3;
			end
			MODE_BSPLINE: begin
				w[0] = div_away(om3, 6);
				w[1] = div_away(3 * m3 - 6 * m2 + 4 * one, 6);
				w[2] = div_away(-3 * m3 + 3 * m2 + 3 * m + one, 6);
				w[3] = div_away(m3, 6);
			end
			default: begin
				w[0] = div_away(-m3 + 2 * m2 - m, 2);
				w[1] = div_away(3 * m3 - 5 * m2 + 2 * one, 2);
				w[2] = div_away(-3 * m3 + 4 * m2 + m, 2);
				w[3] = div_away(m3 - m2, 2);
			end
		endcase
		acc = 0;
		for (i = 0; i < 4; i++)
			acc += w[i] * cv[i];
		r = div_away(acc, one);
		if (r > VAL_HI)
			r = VAL_HI;
		if (r < VAL_LO)
			r = VAL_LO;
		res.value = PT_W'(r);
		res.mparam = PRM_W'(m);
		res.ok = 1'b1;
		return res;
	endfunction

	// control value: small signed or full range, some extremes
	function automatic logic [PT_W-1:0] rand_value();
		int k;
		k = $urandom_range(9);
		if (k < 4)
			return PT_W'($urandom_range(32'h001F_FFFF) - 32'h0010_0000);
		else if (k < 8)
			return PT_W'($urandom());
		case ($urandom_range(3))
			0: return V_MAX;
			1: return V_MIN;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	// random sample: mostly valid ranges, a few of each failing kind
	function automatic sample_t gen_sample();
		sample_t s;
		int k, i;
		s.phantom = 4'($urandom_range(15));
		for (i = 0; i < 4; i++) begin
			s.ctl[i] = rand_value();
			s.nbr[i] = rand_value();
		end
		k = $urandom_range(99);
		if (k < 3) begin
			// parameter above one
			s.local_param = PRM_W'($urandom_range(ONE + 1, PRM_MAX));
			s.seg_start = PRM_W'($urandom());
			s.seg_end = PRM_W'($urandom());
		end else if (k < 6) begin
			// reversed segment
			s.seg_start = PRM_W'($urandom_range(1, ONE));
			s.seg_end = PRM_W'($urandom_range(0, int'(s.seg_start) - 1));
			s.local_param = PRM_W'($urandom_range(ONE));
		end else if (k < 9) begin
			// segment end above one
			s.seg_start = PRM_W'($urandom());
			s.seg_end = PRM_W'($urandom_range(ONE + 1, PRM_MAX));
			s.local_param = PRM_W'($urandom_range(ONE));
		end else begin
			if (k < 40) begin
				s.seg_start = '0;
				s.seg_end = PRM_W'(ONE);
			end else begin
				s.seg_start = PRM_W'($urandom_range(ONE));
				s.seg_end = PRM_W'($urandom_range(int'(s.seg_start), ONE));
			end
			case ($urandom_range(9))
				0: s.local_param = '0;
				1: s.local_param = PRM_W'(ONE);
				default: s.local_param = PRM_W'($urandom_range(ONE));
			endcase
		end
		return s;
	endfunction

	// directed row; ctl and nbr are given as {d, c, b, a}
	task automatic add_row(input logic [1:0] md, input int u, input int u0, input int u1,
		input logic [3:0][PT_W-1:0] cv, input logic [3:0][PT_W-1:0] nv, input logic [3:0] pm,
		input bit fixed, input logic [PT_W-1:0] wv, input int wm, input bit wok);
		dir_row_t row;
		row.md = md;
		row.smp.local_param = PRM_W'(u);
		row.smp.seg_start = PRM_W'(u0);
		row.smp.seg_end = PRM_W'(u1);
		row.smp.ctl = cv;
		row.smp.nbr = nv;
		row.smp.phantom = pm;
		row.fixed = fixed;
		row.want.value = wv;
		row.want.mparam = PRM_W'(wm);
		row.want.ok = wok;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	task automatic log_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	// drive one input word and record its expected point once it is taken
	task automatic send_sample(input sample_t smp, input bit fixed, input point_t want);
		logic [IN_DATA_W-1:0] word;
		point_t pt;
		int i;
		word = '0;
		word[LP_LSB +: PRM_W] = smp.local_param;
		word[SS_LSB +: PRM_W] = smp.seg_start;
		word[SE_LSB +: PRM_W] = smp.seg_end;
		for (i = 0; i < 4; i++) begin
			word[PT_LSB + i * PT_W +: PT_W] = smp.ctl[i];
			word[NB_LSB + i * PT_W +: PT_W] = smp.nbr[i];
		end
		pt = fixed ? want : eval_curve_point(smp, cur_mode);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= smp.phantom;
		do @(posedge clk); while (!s_axis_tready);
		pending_points.insert(pending_points.size(), pt);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
	endtask

	// mode is only changed with the pipeline empty
	task automatic set_mode(input logic [1:0] md);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= md;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_mode = md;
	endtask

	// receiver back-pressure
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_pt.value = m_axis_tdata[PT_W-1:0];
			got_pt.mparam = m_axis_tdata[PT_W +: PRM_W];
			got_pt.ok = m_axis_tuser[0];
			if (pending_points.size() == 0) begin
				log_error($sformatf("unexpected word: value %h m %h ok %b",
					got_pt.value, got_pt.mparam, got_pt.ok));
			end else begin
				want_pt = pending_points.pop_front();
				if (got_pt.value !== want_pt.value || got_pt.mparam !== want_pt.mparam ||
					got_pt.ok !== want_pt.ok)
					log_error($sformatf("exp value %h m %h ok %b, got value %h m %h ok %b",
						want_pt.value, want_pt.mparam, want_pt.ok,
						got_pt.value, got_pt.mparam, got_pt.ok));
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		point_t no_pt;
		int blk, n;
		no_pt = '0;

		// linear: ends, failing ranges, saturation, phantoms
		add_row(MODE_LINEAR, 0, 0, ONE, {V_MIN, V_MAX, 32'h0002_0000, 32'h0001_0000}, '0,
			4'h0, 1'b1, 32'h0001_0000, 0, 1'b1);
		add_row(MODE_LINEAR, ONE, 0, ONE, {V_MIN, V_MAX, 32'h0002_0000, 32'h0001_0000}, '0,
			4'h0, 1'b1, 32'h0002_0000, ONE, 1'b1);
		add_row(MODE_LINEAR, ONE + 1, 0, ONE, {4{32'h0001_0000}}, '0,
			4'h0, 1'b1, '0, 0, 1'b0);
		add_row(MODE_LINEAR, PRM_MAX, PRM_MAX, PRM_MAX, {4{V_MAX}}, {4{V_MIN}},
			4'hF, 1'b1, '0, 0, 1'b0);
		add_row(MODE_LINEAR, 'h8000, ONE, 0, {4{32'h0001_0000}}, '0,
			4'h0, 1'b1, '0, 0, 1'b0);
		add_row(MODE_LINEAR, 'h8000, 0, ONE + 1, {4{32'h0001_0000}}, '0,
			4'h0, 1'b1, '0, 0, 1'b0);
		add_row(MODE_LINEAR, 0, 0, ONE, {32'd0, 32'd0, 32'd0, V_MAX}, {32'd0, 32'd0, 32'd0, V_MIN},
			4'h1, 1'b1, V_MAX, 0, 1'b1);
		add_row(MODE_LINEAR, ONE, 0, ONE, {32'd0, 32'd0, V_MIN, 32'd0}, {32'd0, 32'd0, V_MAX, 32'd0},
			4'h2, 1'b1, V_MIN, ONE, 1'b1);
		add_row(MODE_LINEAR, 1, 0, 'h8000, {32'h0, 32'h0, 32'h0765_4321, 32'h0123_4567}, '0,
			4'h0, 1'b0, '0, 0, 1'b0);
		add_row(MODE_LINEAR, 'h8000, 'h4000, 'hC000,
			{32'h7000_0000, 32'h9000_0000, 32'hFFFF_8000, 32'h0000_8001},
			{32'h1234_5678, 32'h8765_4321, 32'h0000_0001, 32'hFFFF_FFFF},
			4'hF, 1'b0, '0, 0, 1'b0);
		// Bezier: ends give the outer controls
		add_row(MODE_BEZIER, 0, 0, ONE, {32'h4000_0000, 32'hC000_0000, 32'hFFFF_0001, 32'h1234_5678},
			{4{V_MIN}}, 4'h0, 1'b1, 32'h1234_5678, 0, 1'b1);
		add_row(MODE_BEZIER, ONE, 0, ONE, {32'h4000_0000, 32'hC000_0000, 32'hFFFF_0001, 32'h1234_5678},
			{4{V_MIN}}, 4'h0, 1'b1, 32'h4000_0000, ONE, 1'b1);
		add_row(MODE_BEZIER, 'h8000, 0, ONE,
			{32'h4000_0000, 32'hC000_0000, 32'hFFFF_0001, 32'h1234_5678},
			{32'h0000_1000, 32'hFFFF_F000, 32'h0100_0000, 32'hFF00_0000},
			4'hF, 1'b0, '0, 0, 1'b0);
		add_row(MODE_BEZIER, ONE, 'h8000, 'h8000, {32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 32'h0},
			'0, 4'h0, 1'b0, '0, 0, 1'b0);
		// B-spline
		add_row(MODE_BSPLINE, 0, 0, ONE, {4{32'h0001_0000}}, '0, 4'h0, 1'b0, '0, 0, 1'b0);
		add_row(MODE_BSPLINE, ONE, 0, ONE, {4{V_MAX}}, {4{V_MIN}}, 4'hF, 1'b0, '0, 0, 1'b0);
		add_row(MODE_BSPLINE, 'h5555, 'h1000, 'hF000,
			{32'h4000_0000, 32'hC000_0000, 32'hFFFF_0001, 32'h1234_5678},
			{32'h0, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0}, 4'h6, 1'b0, '0, 0, 1'b0);
		// Catmull-Rom: ends give the inner controls
		add_row(MODE_CATROM, 0, 0, ONE, {32'h0505_0505, 32'hF0F0_F0F0, 32'h8000_0001, 32'h7FFF_FFFE},
			'0, 4'h0, 1'b1, 32'h8000_0001, 0, 1'b1);
		add_row(MODE_CATROM, ONE, 0, ONE, {32'h0505_0505, 32'hF0F0_F0F0, 32'h8000_0001, 32'h7FFF_FFFE},
			'0, 4'h0, 1'b1, 32'hF0F0_F0F0, ONE, 1'b1);
		add_row(MODE_CATROM, 'h4000, 0, ONE,
			{32'hFFFF_FFFD, 32'hFFFE_0001, 32'hFFFF_7FFF, 32'hFFFF_FFFF}, '0,
			4'h0, 1'b0, '0, 0, 1'b0);
		add_row(MODE_CATROM, 'hC000, 'h2000, ONE, {V_MIN, V_MAX, V_MIN, V_MAX},
			{V_MAX, V_MIN, V_MAX, V_MIN}, 4'hA, 1'b0, '0, 0, 1'b0);
		add_row(MODE_CATROM, 'h8000, ONE, ONE - 1, {4{32'h0001_0000}}, '0,
			4'h0, 1'b1, '0, 0, 1'b0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, mode rewritten between groups
		foreach (dir_rows[i]) begin
			if (dir_rows[i].md != cur_mode)
				set_mode(dir_rows[i].md);
			send_sample(dir_rows[i].smp, dir_rows[i].fixed, dir_rows[i].want);
		end

		// random blocks: every mode twice, each idle pattern over two modes
		for (blk = 0; blk < RAND_BLOCKS; blk++) begin
			set_mode(2'(blk));
			case (blk / 2)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 77; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 77; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			for (n = 0; n < BLOCK_ITEMS; n++)
				send_sample(gen_sample(), 1'b0, no_pt);
		end

		wait_drained();
		repeat (NUM_STG + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
